// File: rtl/core/cst_pkg.sv
// shared types, constants and token functions for the c subset tokenizer
// no dependencies; used by every file under rtl/core
package cst_pkg;

    localparam int POS_W_DEFAULT = 32;
    localparam int Q_DEPTH       = 4;
    localparam int PREFIX_DEPTH  = 6;
    localparam int NUM_KW        = 9;
    localparam int HASH_SHIFT    = 5;
    localparam logic [31:0] HASH_MASK = 32'h7FFF_FFFF;
    localparam logic [7:0]  LEN_MAX   = 8'd255;

    localparam logic [4:0] KIND_MAIN   = 5'd2;
    localparam logic [4:0] KIND_ASSIGN = 5'd9;
    localparam logic [4:0] KIND_RELOP  = 5'd10;
    localparam logic [4:0] KIND_ADD    = 5'd11;
    localparam logic [4:0] KIND_MINUS  = 5'd12;
    localparam logic [4:0] KIND_STAR   = 5'd13;
    localparam logic [4:0] KIND_DIV    = 5'd14;
    localparam logic [4:0] KIND_MOD    = 5'd15;
    localparam logic [4:0] KIND_POWER  = 5'd16;
    localparam logic [4:0] KIND_AND    = 5'd17;
    localparam logic [4:0] KIND_SAND   = 5'd18;
    localparam logic [4:0] KIND_OR     = 5'd19;
    localparam logic [4:0] KIND_NOT    = 5'd20;
    localparam logic [4:0] KIND_LP     = 5'd21;
    localparam logic [4:0] KIND_RP     = 5'd22;
    localparam logic [4:0] KIND_LB     = 5'd23;
    localparam logic [4:0] KIND_RB     = 5'd24;
    localparam logic [4:0] KIND_LBRACE = 5'd25;
    localparam logic [4:0] KIND_RBRACE = 5'd26;
    localparam logic [4:0] KIND_SEMI   = 5'd27;
    localparam logic [4:0] KIND_COMMA  = 5'd28;
    localparam logic [4:0] KIND_MEMBER = 5'd29;
    localparam logic [4:0] KIND_ID     = 5'd30;
    localparam logic [4:0] KIND_INT    = 5'd31;

    localparam logic [2:0] RELOP_NONE = 3'd0;
    localparam logic [2:0] RELOP_GE   = 3'd0;
    localparam logic [2:0] RELOP_LE   = 3'd1;
    localparam logic [2:0] RELOP_EQ   = 3'd2;
    localparam logic [2:0] RELOP_NE   = 3'd3;
    localparam logic [2:0] RELOP_LT   = 3'd4;
    localparam logic [2:0] RELOP_GT   = 3'd5;

    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LCUR   = 8'h7B;
    localparam logic [7:0] CH_RCUR   = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam logic [7:0] KW_TEXT [NUM_KW][PREFIX_DEPTH] = '{
        '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00},
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h6D, 8'h61, 8'h69, 8'h6E, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E},
        '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},
        '{8'h73, 8'h74, 8'h72, 8'h75, 8'h63, 8'h74}
    };
    localparam logic [7:0] KW_LEN [NUM_KW] = '{
        8'd4, 8'd3, 8'd4, 8'd6, 8'd3, 8'd5, 8'd2, 8'd4, 8'd6
    };

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_OP   = 4'b0010,
        MODE_WORD = 4'b0100,
        MODE_NUM  = 4'b1000
    } t_mode;

    typedef logic [PREFIX_DEPTH-1:0][7:0] t_prefix;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_in_beat;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [2:0]  relop_kind;
        logic [31:0] attribute;
        logic        value_overflow;
        logic [31:0] token_start;
        logic [7:0]  token_length;
        logic        last_of_run;
    } t_out_beat;

    typedef struct packed {
        logic      vld;
        t_out_beat beat;
    } t_tok;

    typedef struct packed {
        logic      two;
        t_out_beat first;
        t_out_beat second;
    } t_step;

    typedef struct packed {
        logic  vld;
        t_step step;
    } t_step_xfer;

    typedef struct packed {
        logic       vld;
        logic [4:0] kind;
    } t_imm;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic logic is_pend(logic [7:0] c);
        return c == CH_EQ || c == CH_LT || c == CH_GT || c == CH_BANG
            || c == CH_AMP || c == CH_BAR;
    endfunction

    function automatic t_imm imm_kind(logic [7:0] c);
        t_imm r;
        r.vld  = 1'b1;
        r.kind = KIND_ADD;
        case (c)
            CH_PLUS:  r.kind = KIND_ADD;
            CH_MINUS: r.kind = KIND_MINUS;
            CH_STAR:  r.kind = KIND_STAR;
            CH_SLASH: r.kind = KIND_DIV;
            CH_PCT:   r.kind = KIND_MOD;
            CH_CARET: r.kind = KIND_POWER;
            CH_LPAR:  r.kind = KIND_LP;
            CH_RPAR:  r.kind = KIND_RP;
            CH_LBRK:  r.kind = KIND_LB;
            CH_RBRK:  r.kind = KIND_RB;
            CH_LCUR:  r.kind = KIND_LBRACE;
            CH_RCUR:  r.kind = KIND_RBRACE;
            CH_SEMI:  r.kind = KIND_SEMI;
            CH_COMMA: r.kind = KIND_COMMA;
            CH_DOT:   r.kind = KIND_MEMBER;
            default:  r.vld  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_tok mk_tok(logic [4:0] kind, logic [2:0] relop, logic [31:0] attr,
                                    logic ovf, logic [31:0] start, logic [7:0] len);
        t_tok t;
        t.vld                 = 1'b1;
        t.beat.token_kind     = kind;
        t.beat.relop_kind     = relop;
        t.beat.attribute      = attr;
        t.beat.value_overflow = ovf;
        t.beat.token_start    = start;
        t.beat.token_length   = len;
        t.beat.last_of_run    = 1'b0;
        return t;
    endfunction

    // token for whatever is pending in the given scan state
    function automatic t_tok flush_tok(t_mode mode, logic [7:0] pend, t_prefix prefix,
                                       logic [7:0] len, logic [31:0] hash,
                                       logic [31:0] value, logic sat, logic [31:0] start);
        t_tok       t;
        logic       hit;
        logic       same;
        logic [4:0] kw;
        t   = '0;
        hit = 1'b0;
        kw  = '0;
        case (mode)
            MODE_OP: begin
                case (pend)
                    CH_EQ:   t = mk_tok(KIND_ASSIGN, RELOP_NONE, '0, 1'b0, start, 8'd1);
                    CH_LT:   t = mk_tok(KIND_RELOP, RELOP_LT, '0, 1'b0, start, 8'd1);
                    CH_GT:   t = mk_tok(KIND_RELOP, RELOP_GT, '0, 1'b0, start, 8'd1);
                    CH_BANG: t = mk_tok(KIND_NOT, RELOP_NONE, '0, 1'b0, start, 8'd1);
                    CH_AMP:  t = mk_tok(KIND_SAND, RELOP_NONE, '0, 1'b0, start, 8'd1);
                    default: t = '0;
                endcase
            end
            MODE_WORD: begin
                for (int k = NUM_KW - 1; k >= 0; k--) begin
                    same = (len == KW_LEN[k]);
                    for (int i = 0; i < PREFIX_DEPTH; i++) begin
                        if (8'(i) < KW_LEN[k] && prefix[i] != KW_TEXT[k][i]) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        hit = 1'b1;
                        kw  = 5'(k);
                    end
                end
                if (!hit) begin
                    t = mk_tok(KIND_ID, RELOP_NONE, hash & HASH_MASK, 1'b0, start, len);
                end else if (kw == KIND_MAIN) begin
                    t = mk_tok(kw, RELOP_NONE, hash & HASH_MASK, 1'b0, start, len);
                end else begin
                    t = mk_tok(kw, RELOP_NONE, '0, 1'b0, start, len);
                end
            end
            MODE_NUM: t = mk_tok(KIND_INT, RELOP_NONE, value, sat, start, len);
            default:  t = '0;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/core/c_subset_tokenizer_top.sv
// top level of the c subset tokenizer: front end, pair queue and output stage
// depends on cst_pkg, cst_front, cst_fifo, cst_back
//
// One source byte is taken per cycle while input ready is high and scanned in the same cycle;
// each byte yields zero, one or two tokens, which wait as a pair in a four-entry queue and
// leave one beat per cycle while the output is ready, via the queue and the output register.
// Bytes flow at one per cycle as long as they average no more than one token each; the single
// output beat per cycle sets the long-run rate, and bursts of two-token bytes are absorbed by
// the queue before input ready drops. A byte flagged as end of input flushes the pending token
// and restarts offsets at zero for the next stream. There is no startup pass after reset.
module c_subset_tokenizer_top #(
    parameter int POSITION_WIDTH = cst_pkg::POS_W_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cst_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cst_pkg::t_out_beat o_out_beat
);

    cst_pkg::t_step_xfer push;
    cst_pkg::t_step_xfer head;
    logic                q_full;
    logic                pop;

    cst_front #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    cst_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    cst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    a_ovf_is_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.value_overflow |->
            o_out_beat.token_kind == cst_pkg::KIND_INT
            && o_out_beat.attribute == 32'hFFFF_FFFF)
        else $error("overflow flag on a non-saturated token");

    a_relop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.token_kind != cst_pkg::KIND_RELOP |->
            o_out_beat.relop_kind == cst_pkg::RELOP_NONE)
        else $error("relop kind set on a non-relational token");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_beat.last_of_run |=>
            o_out_valid && o_out_beat.last_of_run)
        else $error("second token of a pair did not follow");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_beat.token_length != 8'd0)
        else $error("token with zero length");

endmodule

// File: rtl/core/cst_front.sv
// front end: accepts source bytes, runs the scan state and builds token pairs
// depends on cst_pkg
module cst_front #(
    parameter int POSITION_WIDTH = cst_pkg::POS_W_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cst_pkg::t_in_beat  i_in_beat,
    input  logic               i_q_full,
    output cst_pkg::t_step_xfer o_push
);

    cst_pkg::t_mode             r_mode, n_mode;
    logic [7:0]                 r_pend, n_pend;
    cst_pkg::t_prefix           r_prefix, n_prefix;
    logic [7:0]                 r_len, n_len;
    logic [31:0]                r_hash, n_hash;
    logic [31:0]                r_value, n_value;
    logic                       r_sat, n_sat;
    logic [POSITION_WIDTH-1:0]  r_start, n_start;
    logic [POSITION_WIDTH-1:0]  r_pos, n_pos;

    logic                       accept;
    logic [7:0]                 c;
    logic                       eoi;
    logic                       used;
    logic [35:0]                prod;
    cst_pkg::t_tok              p1, p2, p3, first, second;
    cst_pkg::t_imm              imm;

    function automatic logic [31:0] to_start(logic [POSITION_WIDTH-1:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[31:0];
    endfunction

    assign o_in_ready = i_rst_n && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign c          = i_in_beat.char_byte;
    assign eoi        = i_in_beat.end_of_input;

    always_comb begin
        n_mode   = r_mode;
        n_pend   = r_pend;
        n_prefix = r_prefix;
        n_len    = r_len;
        n_hash   = r_hash;
        n_value  = r_value;
        n_sat    = r_sat;
        n_start  = r_start;
        n_pos    = r_pos + POSITION_WIDTH'(1);
        used     = 1'b0;
        p1       = '0;
        p2       = '0;
        p3       = '0;
        imm      = cst_pkg::imm_kind(c);
        prod     = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1) + 36'(c[3:0]);

        case (r_mode)
            cst_pkg::MODE_OP: begin
                n_mode = cst_pkg::MODE_IDLE;
                used   = 1'b1;
                if (c == cst_pkg::CH_EQ && r_pend == cst_pkg::CH_EQ) begin
                    p1 = cst_pkg::mk_tok(cst_pkg::KIND_RELOP, cst_pkg::RELOP_EQ, '0, 1'b0,
                                         to_start(r_start), 8'd2);
                end else if (c == cst_pkg::CH_EQ && r_pend == cst_pkg::CH_GT) begin
                    p1 = cst_pkg::mk_tok(cst_pkg::KIND_RELOP, cst_pkg::RELOP_GE, '0, 1'b0,
                                         to_start(r_start), 8'd2);
                end else if (c == cst_pkg::CH_EQ && r_pend == cst_pkg::CH_LT) begin
                    p1 = cst_pkg::mk_tok(cst_pkg::KIND_RELOP, cst_pkg::RELOP_LE, '0, 1'b0,
                                         to_start(r_start), 8'd2);
                end else if (c == cst_pkg::CH_EQ && r_pend == cst_pkg::CH_BANG) begin
                    p1 = cst_pkg::mk_tok(cst_pkg::KIND_RELOP, cst_pkg::RELOP_NE, '0, 1'b0,
                                         to_start(r_start), 8'd2);
                end else if (c == cst_pkg::CH_AMP && r_pend == cst_pkg::CH_AMP) begin
                    p1 = cst_pkg::mk_tok(cst_pkg::KIND_AND, cst_pkg::RELOP_NONE, '0, 1'b0,
                                         to_start(r_start), 8'd2);
                end else if (c == cst_pkg::CH_BAR && r_pend == cst_pkg::CH_BAR) begin
                    p1 = cst_pkg::mk_tok(cst_pkg::KIND_OR, cst_pkg::RELOP_NONE, '0, 1'b0,
                                         to_start(r_start), 8'd2);
                end else begin
                    used = 1'b0;
                    p1   = cst_pkg::flush_tok(r_mode, r_pend, r_prefix, r_len, r_hash,
                                              r_value, r_sat, to_start(r_start));
                end
            end
            cst_pkg::MODE_WORD: begin
                if (cst_pkg::is_word(c)) begin
                    used = 1'b1;
                    if (r_len < 8'(cst_pkg::PREFIX_DEPTH)) begin
                        n_prefix[r_len[2:0]] = c;
                    end
                    n_hash = (r_hash << cst_pkg::HASH_SHIFT) + {24'b0, c};
                    n_len  = (r_len == cst_pkg::LEN_MAX) ? r_len : r_len + 8'd1;
                end else begin
                    n_mode = cst_pkg::MODE_IDLE;
                    p1     = cst_pkg::flush_tok(r_mode, r_pend, r_prefix, r_len, r_hash,
                                                r_value, r_sat, to_start(r_start));
                end
            end
            cst_pkg::MODE_NUM: begin
                if (cst_pkg::is_digit(c)) begin
                    used = 1'b1;
                    if (prod[35:32] != 4'd0) begin
                        n_value = 32'hFFFF_FFFF;
                        n_sat   = 1'b1;
                    end else begin
                        n_value = prod[31:0];
                    end
                    n_len = (r_len == cst_pkg::LEN_MAX) ? r_len : r_len + 8'd1;
                end else begin
                    n_mode = cst_pkg::MODE_IDLE;
                    p1     = cst_pkg::flush_tok(r_mode, r_pend, r_prefix, r_len, r_hash,
                                                r_value, r_sat, to_start(r_start));
                end
            end
            default: ;
        endcase

        if (!used) begin
            if (cst_pkg::is_pend(c)) begin
                n_mode  = cst_pkg::MODE_OP;
                n_pend  = c;
                n_start = r_pos;
            end else if (imm.vld) begin
                p2 = cst_pkg::mk_tok(imm.kind, cst_pkg::RELOP_NONE, '0, 1'b0,
                                     to_start(r_pos), 8'd1);
            end else if (cst_pkg::is_alpha(c) || c == cst_pkg::CH_UNDER) begin
                n_mode      = cst_pkg::MODE_WORD;
                n_prefix[0] = c;
                n_hash      = {24'b0, c};
                n_len       = 8'd1;
                n_start     = r_pos;
            end else if (cst_pkg::is_digit(c)) begin
                n_mode  = cst_pkg::MODE_NUM;
                n_value = {28'b0, c[3:0]};
                n_sat   = 1'b0;
                n_len   = 8'd1;
                n_start = r_pos;
            end
        end

        if (eoi) begin
            p3      = cst_pkg::flush_tok(n_mode, n_pend, n_prefix, n_len, n_hash,
                                         n_value, n_sat, to_start(n_start));
            n_mode  = cst_pkg::MODE_IDLE;
            n_pend  = '0;
            n_len   = '0;
            n_hash  = '0;
            n_value = '0;
            n_sat   = 1'b0;
            n_start = '0;
            n_pos   = '0;
        end

        // compact the up to two tokens in stream order
        first  = p1.vld ? p1 : (p2.vld ? p2 : p3);
        second = p1.vld ? (p2.vld ? p2 : p3) : '0;
        first.beat.last_of_run  = !second.vld;
        second.beat.last_of_run = 1'b1;
    end

    assign o_push.vld         = accept && first.vld;
    assign o_push.step.two    = second.vld;
    assign o_push.step.first  = first.beat;
    assign o_push.step.second = second.beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= cst_pkg::MODE_IDLE;
            r_pend  <= '0;
            r_len   <= '0;
            r_hash  <= '0;
            r_value <= '0;
            r_sat   <= 1'b0;
            r_start <= '0;
            r_pos   <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_len   <= n_len;
            r_hash  <= n_hash;
            r_value <= n_value;
            r_sat   <= n_sat;
            r_start <= n_start;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prefix <= n_prefix;
        end
    end

endmodule

// File: rtl/core/cst_fifo.sv
// short queue of token pairs between the front end and the output stage
// depends on cst_pkg
module cst_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cst_pkg::t_step_xfer i_push,
    output logic                o_full,
    output cst_pkg::t_step_xfer o_head,
    input  logic                i_pop
);

    localparam int DEPTH = cst_pkg::Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cst_pkg::t_step      r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_head.vld  = (r_count != '0);
    assign o_head.step = r_mem[r_rd_ptr];
    assign do_push     = i_push.vld && !o_full;
    assign do_pop      = i_pop && o_head.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!do_push && do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.step;
        end
    end

endmodule

// File: rtl/core/cst_back.sv
// output stage: splits queued token pairs into single beats on the result channel
// depends on cst_pkg
module cst_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cst_pkg::t_step_xfer i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cst_pkg::t_out_beat  o_out_beat
);

    logic               r_vld;
    logic               r_second;
    cst_pkg::t_out_beat r_out;
    cst_pkg::t_out_beat r_hold;
    logic               load;

    assign load        = !r_vld || i_out_ready;
    assign o_pop       = load && !r_second && i_head.vld;
    assign o_out_valid = r_vld;
    assign o_out_beat  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            if (r_second) begin
                r_vld    <= 1'b1;
                r_second <= 1'b0;
            end else if (i_head.vld) begin
                r_vld    <= 1'b1;
                r_second <= i_head.step.two;
            end else begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_second) begin
                r_out <= r_hold;
            end else if (i_head.vld) begin
                r_out  <= i_head.step.first;
                r_hold <= i_head.step.second;
            end
        end
    end

endmodule
